[design/ame_pkg.sv]
// Shared types and constants of the accumulator machine execute block.
package ame_pkg;

   localparam int ADDR_W = 12;
   localparam int IDX_W  = 13;
   localparam int DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;

   // Opcodes as they arrive on the request channel
   localparam logic [3:0] OP_INP   = 4'd0;
   localparam logic [3:0] OP_MOV   = 4'd1;
   localparam logic [3:0] OP_OUT   = 4'd2;
   localparam logic [3:0] OP_ADD   = 4'd3;
   localparam logic [3:0] OP_SUB   = 4'd4;
   localparam logic [3:0] OP_BRA   = 4'd5;
   localparam logic [3:0] OP_BEZ   = 4'd6;
   localparam logic [3:0] OP_BGZ   = 4'd7;
   localparam logic [3:0] OP_BLZ   = 4'd8;
   localparam logic [3:0] OP_HLT   = 4'd9;
   localparam logic [3:0] OP_LABEL = 4'd10;

   localparam logic [1:0] SK_IMM = 2'd0;
   localparam logic [1:0] SK_ACC = 2'd1;
   localparam logic [1:0] SK_MEM = 2'd2;

   typedef enum logic [3:0] {
      CLS_MOV,
      CLS_OUT,
      CLS_ADD,
      CLS_SUB,
      CLS_BRA,
      CLS_BEZ,
      CLS_BGZ,
      CLS_BLZ,
      CLS_HLT,
      CLS_NOP
   } op_class_type;

   typedef enum logic [1:0] {
      SRC_IMM,
      SRC_ACC,
      SRC_MEM
   } src_sel_type;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_LABEL = 2'd1,
      FAULT_ADDR  = 2'd2
   } fault_type;

   typedef struct packed {
      op_class_type        cls;
      src_sel_type         src;
      logic [DATA_W-1:0]   imm;
      logic                dst_mem;
      logic [ADDR_W-1:0]   rd_addr;
      logic [ADDR_W-1:0]   wr_addr;
      logic                addr_fault;
      logic [ADDR_W-1:0]   target;
      logic                known;
   } dec_type;

endpackage

[design/accumulator_machine_execute.sv]
// Top level of the accumulator machine execute block.
// Path: an accepted request item is loaded into the front register, then passes through
// the queue and the execute stage; rsp_valid rises when its result register is loaded.
// Throughput: one item per cycle while rsp_ready stays high, set by the execute stage and
// forwarding from the data memory write port into the next item's read.
// Reset: synchronous; after reset the data memory is cleared word by word, during which
// req_ready stays low; csr writes are taken throughout.
module accumulator_machine_execute
   import ame_pkg::*;
#(
   parameter int MEM_WORDS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [12:0]         csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_op,
   input  logic [1:0]          req_src_kind,
   input  logic signed [31:0]  req_src_value,
   input  logic                req_dest_kind,
   input  logic [11:0]         req_dest_addr,
   input  logic [11:0]         req_branch_target,
   input  logic                req_target_known,
   input  logic signed [31:0]  req_input_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [12:0]         rsp_next_index,
   output logic                rsp_out_valid,
   output logic signed [31:0]  rsp_out_value,
   output logic signed [31:0]  rsp_acc_now,
   output logic                rsp_halted,
   output logic [1:0]          rsp_fault
);

   // program length register; the user writes it only while idle, not enforced by the block
   logic [IDX_W-1:0] plen_ff;

   // front to queue
   logic    push_valid, push_ready;
   dec_type push_data;

   // queue to back
   logic    pop_valid, pop;
   dec_type pop_data;

   // back holds off the front while the data memory is being cleared
   logic    clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
      end else if (csr_wr_en) begin
         plen_ff <= csr_wr_data;
      end
   end

   // classify the item and check its addresses against the memory size
   ame_front #(
      .MEM_WORDS (MEM_WORDS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_src_kind      (req_src_kind),
      .req_src_value     (req_src_value),
      .req_dest_kind     (req_dest_kind),
      .req_dest_addr     (req_dest_addr),
      .req_branch_target (req_branch_target),
      .req_target_known  (req_target_known),
      .req_input_value   (req_input_value),
      .blocked           (clearing),
      .push_valid        (push_valid),
      .push_data         (push_data),
      .push_ready        (push_ready)
   );

   // decouple the front from back-pressure on the result side
   ame_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop)
   );

   // read operands, execute, update state and register the result item
   ame_back #(
      .MEM_WORDS (MEM_WORDS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .program_length (plen_ff),
      .pop_valid      (pop_valid),
      .pop_data       (pop_data),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_index (rsp_next_index),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_acc_now    (rsp_acc_now),
      .rsp_halted     (rsp_halted),
      .rsp_fault      (rsp_fault)
   );

endmodule

[design/ame_front.sv]
// Front end: accepts request items, classifies them and checks addresses.
module ame_front
   import ame_pkg::*;
#(
   parameter int MEM_WORDS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_op,
   input  logic [1:0]          req_src_kind,
   input  logic signed [31:0]  req_src_value,
   input  logic                req_dest_kind,
   input  logic [11:0]         req_dest_addr,
   input  logic [11:0]         req_branch_target,
   input  logic                req_target_known,
   input  logic signed [31:0]  req_input_value,
   input  logic                blocked,
   output logic                push_valid,
   output dec_type             push_data,
   input  logic                push_ready
);

   logic    fv_ff, fv_in;
   dec_type fd_ff, dec;
   logic    uses_src, src_oob, dst_oob;

   always_comb begin
      dec          = '0;
      dec.cls      = CLS_NOP;
      dec.src      = SRC_IMM;
      dec.imm      = req_src_value;
      dec.dst_mem  = 1'b0;
      dec.rd_addr  = req_src_value[ADDR_W-1:0];
      dec.wr_addr  = req_dest_addr;
      dec.target   = req_branch_target;
      dec.known    = req_target_known;
      uses_src     = 1'b0;
      unique case (req_op)
         OP_INP: begin
            // load of the user value: a move of an immediate into the accumulator
            dec.cls = CLS_MOV;
            dec.imm = req_input_value;
         end
         OP_MOV: begin
            dec.cls     = CLS_MOV;
            dec.dst_mem = req_dest_kind;
            uses_src    = 1'b1;
         end
         OP_OUT: begin
            dec.cls  = CLS_OUT;
            uses_src = 1'b1;
         end
         OP_ADD: begin
            dec.cls  = CLS_ADD;
            uses_src = 1'b1;
         end
         OP_SUB: begin
            dec.cls  = CLS_SUB;
            uses_src = 1'b1;
         end
         OP_BRA:  dec.cls = CLS_BRA;
         OP_BEZ:  dec.cls = CLS_BEZ;
         OP_BGZ:  dec.cls = CLS_BGZ;
         OP_BLZ:  dec.cls = CLS_BLZ;
         OP_HLT:  dec.cls = CLS_HLT;
         default: dec.cls = CLS_NOP;
      endcase
      if (uses_src) begin
         case (req_src_kind)
            SK_ACC:  dec.src = SRC_ACC;
            SK_MEM:  dec.src = SRC_MEM;
            default: dec.src = SRC_IMM;
         endcase
      end
      src_oob = (dec.src == SRC_MEM) &&
                ($unsigned(req_src_value) >= DATA_W'(MEM_WORDS));
      dst_oob = dec.dst_mem && ({1'b0, req_dest_addr} >= IDX_W'(MEM_WORDS));
      dec.addr_fault = src_oob || dst_oob;
   end

   assign req_ready  = !blocked && (!fv_ff || push_ready);
   assign push_valid = fv_ff;
   assign push_data  = fd_ff;

   always_comb begin
      fv_in = fv_ff;
      if (push_valid && push_ready) begin
         fv_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         fv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         fd_ff <= dec;
      end
   end

endmodule

[design/ame_queue.sv]
// Two-entry queue of classified items between front and back.
module ame_queue
   import ame_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  dec_type push_data,
   output logic    push_ready,
   output logic    pop_valid,
   output dec_type pop_data,
   input  logic    pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   dec_type            q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = q_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/ame_back.sv]
// Back end: data memory, architectural state, execution and result register.
module ame_back
   import ame_pkg::*;
#(
   parameter int MEM_WORDS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_W-1:0]    program_length,
   input  logic                pop_valid,
   input  dec_type             pop_data,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [12:0]         rsp_next_index,
   output logic                rsp_out_valid,
   output logic signed [31:0]  rsp_out_value,
   output logic signed [31:0]  rsp_acc_now,
   output logic                rsp_halted,
   output logic [1:0]          rsp_fault
);

   localparam int AW = $clog2(MEM_WORDS);

   logic [DATA_W-1:0] mem_ff [MEM_WORDS];
   logic [DATA_W-1:0] rd_data_ff, fwd_data_ff;
   logic              fwd_hit_ff;

   logic              clr_ff;
   logic [AW-1:0]     clr_addr_ff;

   logic              x_valid_ff;
   dec_type           x_ff;

   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              stopped_ff, stopped_in;

   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic              rsp_ov_ff;
   logic [DATA_W-1:0] rsp_oval_ff, rsp_acc_ff;
   logic              rsp_halted_ff;
   fault_type         rsp_fault_ff;

   logic              exec_fire, load_x;
   logic [DATA_W-1:0] src_val, oval;
   logic              ov, take, we_exec;
   fault_type         flt;

   logic              mem_we;
   logic [AW-1:0]     mem_wa, rd_addr;
   logic [DATA_W-1:0] mem_wd;

   assign clearing  = clr_ff;
   assign exec_fire = x_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign load_x    = pop_valid && !clr_ff && (!x_valid_ff || exec_fire);
   assign pop       = load_x;
   assign rd_addr   = pop_data.rd_addr[AW-1:0];

   // execute the item held in the stage against the current state
   always_comb begin
      unique case (x_ff.src)
         SRC_ACC: src_val = acc_ff;
         SRC_MEM: src_val = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
         default: src_val = x_ff.imm;
      endcase
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      stopped_in = stopped_ff;
      ov         = 1'b0;
      oval       = '0;
      flt        = FAULT_NONE;
      take       = 1'b0;
      we_exec    = 1'b0;
      if (stopped_ff) begin
         // hold everything
      end else if (idx_ff >= program_length) begin
         stopped_in = 1'b1;
      end else if (x_ff.addr_fault) begin
         stopped_in = 1'b1;
         flt        = FAULT_ADDR;
      end else begin
         unique case (x_ff.cls)
            CLS_MOV: begin
               if (x_ff.dst_mem) begin
                  we_exec = 1'b1;
               end else begin
                  acc_in = src_val;
               end
            end
            CLS_OUT: begin
               ov   = 1'b1;
               oval = src_val;
            end
            CLS_ADD: acc_in = acc_ff + src_val;
            CLS_SUB: acc_in = acc_ff - src_val;
            CLS_BRA: take = 1'b1;
            CLS_BEZ: take = (acc_ff == '0);
            CLS_BGZ: take = (acc_ff != '0) && !acc_ff[DATA_W-1];
            CLS_BLZ: take = acc_ff[DATA_W-1];
            CLS_HLT: stopped_in = 1'b1;
            default: ;
         endcase
         if (take && !x_ff.known) begin
            stopped_in = 1'b1;
            flt        = FAULT_LABEL;
         end else begin
            idx_in = (take ? {1'b0, x_ff.target} : idx_ff) + 1'b1;
         end
      end
   end

   // memory write port: clearing pass first, then moves to memory
   assign mem_we = clr_ff || (exec_fire && we_exec);
   assign mem_wa = clr_ff ? clr_addr_ff : x_ff.wr_addr[AW-1:0];
   assign mem_wd = clr_ff ? '0 : src_val;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      if (load_x) begin
         rd_data_ff  <= mem_ff[rd_addr];
         fwd_hit_ff  <= mem_we && (mem_wa == rd_addr);
         fwd_data_ff <= mem_wd;
         x_ff        <= pop_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         x_valid_ff  <= 1'b0;
         acc_ff      <= '0;
         idx_ff      <= '0;
         stopped_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(MEM_WORDS - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (load_x) begin
            x_valid_ff <= 1'b1;
         end else if (exec_fire) begin
            x_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            acc_ff     <= acc_in;
            idx_ff     <= idx_in;
            stopped_ff <= stopped_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_idx_ff    <= idx_in;
         rsp_ov_ff     <= ov;
         rsp_oval_ff   <= oval;
         rsp_acc_ff    <= acc_in;
         rsp_halted_ff <= stopped_in;
         rsp_fault_ff  <= flt;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_index = rsp_idx_ff;
   assign rsp_out_valid  = rsp_ov_ff;
   assign rsp_out_value  = rsp_oval_ff;
   assign rsp_acc_now    = rsp_acc_ff;
   assign rsp_halted     = rsp_halted_ff;
   assign rsp_fault      = rsp_fault_ff;

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stop flag dropped without reset");

   a_no_exec_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !x_valid_ff)
      else $error("item in execute during memory clear");

   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_fault_ff != FAULT_NONE) |-> rsp_halted_ff && !rsp_ov_ff)
      else $error("faulting result not halted");

   a_out_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ov_ff |-> rsp_oval_ff == '0)
      else $error("output value set without output");

endmodule

[sim/ame_tb_pkg.sv]
// Instruction and result types plus the shadow machine that predicts and checks results.
`timescale 1ns / 100ps
package ame_tb_pkg;
   import ame_pkg::*;

   localparam int MEM_WORDS = 1024;

   typedef struct packed {
      logic [3:0]  op;
      logic [1:0]  src_kind;
      logic [31:0] src_value;
      logic        dest_kind;
      logic [11:0] dest_addr;
      logic [11:0] branch_target;
      logic        target_known;
      logic [31:0] input_value;
   } instr_type;

   typedef struct packed {
      logic [12:0] next_index;
      logic        out_valid;
      logic [31:0] out_value;
      logic [31:0] acc_now;
      logic        halted;
      logic [1:0]  fault;
   } step_result_type;

   class machine_checker;
      logic [31:0]     acc;
      logic [12:0]     index;
      bit              stopped;
      logic [12:0]     prog_len;
      logic [31:0]     data_mem[];
      step_result_type awaited[$];
      int              mismatches;
      int              executed;
      int              taken_branches;
      int              outputs_seen;

      function new();
         data_mem = new[MEM_WORDS];
         foreach (data_mem[i]) data_mem[i] = '0;
         acc            = '0;
         index          = '0;
         stopped        = 0;
         prog_len       = '0;
         mismatches     = 0;
         executed       = 0;
         taken_branches = 0;
         outputs_seen   = 0;
      endfunction

      function void set_program_length(logic [12:0] len);
         prog_len = len;
      endfunction

      function bit branch_taken(logic [3:0] op);
         case (op)
            OP_BRA:  return 1;
            OP_BEZ:  return acc == '0;
            OP_BGZ:  return (acc != '0) && !acc[31];
            OP_BLZ:  return acc[31];
            default: return 0;
         endcase
      endfunction

      // Run one instruction on the shadow state and return what the block should report.
      function step_result_type execute(instr_type ins);
         step_result_type r;
         logic [31:0]     operand;
         logic [1:0]      flt;
         bit              take;
         r       = '0;
         operand = ins.src_value;
         flt     = FAULT_NONE;
         take    = 0;
         if (!stopped && index >= prog_len) begin
            stopped = 1;
         end else if (!stopped) begin
            if (ins.op >= OP_MOV && ins.op <= OP_SUB) begin
               if (ins.src_kind == SK_ACC) begin
                  operand = acc;
               end else if (ins.src_kind == SK_MEM) begin
                  if (ins.src_value >= MEM_WORDS) flt = FAULT_ADDR;
                  else operand = data_mem[ins.src_value];
               end
            end
            if (ins.op == OP_MOV && ins.dest_kind && ins.dest_addr >= MEM_WORDS)
               flt = FAULT_ADDR;
            if (flt == FAULT_NONE) begin
               case (ins.op)
                  OP_INP: acc = ins.input_value;
                  OP_MOV: begin
                     if (ins.dest_kind) data_mem[ins.dest_addr] = operand;
                     else acc = operand;
                  end
                  OP_OUT: begin
                     r.out_valid = 1'b1;
                     r.out_value = operand;
                  end
                  OP_ADD: acc = acc + operand;
                  OP_SUB: acc = acc - operand;
                  OP_HLT: stopped = 1;
                  default: take = branch_taken(ins.op);
               endcase
               if (take && !ins.target_known) begin
                  flt = FAULT_LABEL;
               end else begin
                  if (take) begin
                     index = {1'b0, ins.branch_target};
                     taken_branches++;
                  end
                  index = index + 13'd1;
               end
            end
            if (flt != FAULT_NONE) begin
               stopped     = 1;
               r.out_valid = 1'b0;
               r.out_value = '0;
            end
         end
         if (r.out_valid) outputs_seen++;
         r.next_index = index;
         r.acc_now    = acc;
         r.halted     = stopped;
         r.fault      = flt;
         return r;
      endfunction

      function void note_instruction(instr_type ins);
         awaited.push_back(execute(ins));
         executed++;
      endfunction

      function void check_result(step_result_type got);
         step_result_type want;
         bit              bad;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] result with nothing outstanding: index %0d acc %h halted %b",
                        $time, got.next_index, got.acc_now, got.halted);
            return;
         end
         want = awaited.pop_front();
         bad = (got.next_index !== want.next_index) || (got.out_valid !== want.out_valid) ||
               (got.out_value !== want.out_value) || (got.acc_now !== want.acc_now) ||
               (got.halted !== want.halted) || (got.fault !== want.fault);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] mismatch  exp: index %0d out %b/%h acc %h halted %b fault %0d",
                        $time, want.next_index, want.out_valid, want.out_value, want.acc_now,
                        want.halted, want.fault);
               $display("            got: index %0d out %b/%h acc %h halted %b fault %0d",
                        got.next_index, got.out_valid, got.out_value, got.acc_now,
                        got.halted, got.fault);
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

endpackage

[sim/tb_top.sv]
// Top of the testbench: clock, reset, stimulus and back-pressure for the execute block.
`timescale 1ns / 100ps
module tb_top;
   import ame_pkg::*;
   import ame_tb_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int PHASE_ITEMS  = 230;
   localparam int SETTLE       = 8;          // a little beyond the latency of the block
   localparam int TIMEOUT_NS   = 5_000_000;  // limit on total simulation time
   localparam logic [12:0] PROG_MAX = 13'd4096;

   // Source kind three has no name in the package; the block treats it as immediate
   localparam logic [1:0] SK_SPARE      = 2'd3;
   localparam logic [3:0] OP_TOP_UNUSED = 4'hF;

   typedef enum int {
      END_HALT,
      END_LABEL,
      END_SRC_ADDR,
      END_DEST_ADDR,
      END_PROGRAM
   } stop_cause_type;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_COIN,
      RX_PATTERN,
      RX_CHOKE
   } rx_mode_type;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               csr_wr_en         = 1'b0;
   logic [12:0]        csr_wr_data       = '0;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [3:0]         req_op            = '0;
   logic [1:0]         req_src_kind      = '0;
   logic signed [31:0] req_src_value     = '0;
   logic               req_dest_kind     = 1'b0;
   logic [11:0]        req_dest_addr     = '0;
   logic [11:0]        req_branch_target = '0;
   logic               req_target_known  = 1'b0;
   logic signed [31:0] req_input_value   = '0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic [12:0]        rsp_next_index;
   logic               rsp_out_valid;
   logic signed [31:0] rsp_out_value;
   logic signed [31:0] rsp_acc_now;
   logic               rsp_halted;
   logic [1:0]         rsp_fault;

   machine_checker shadow;
   int unsigned    burst_left = 0;
   rx_mode_type    rx_mode    = RX_FREE;
   int unsigned    rx_left    = 0;
   int unsigned    rx_phase   = 0;

   accumulator_machine_execute #(.MEM_WORDS(MEM_WORDS)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_src_kind      (req_src_kind),
      .req_src_value     (req_src_value),
      .req_dest_kind     (req_dest_kind),
      .req_dest_addr     (req_dest_addr),
      .req_branch_target (req_branch_target),
      .req_target_known  (req_target_known),
      .req_input_value   (req_input_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_index    (rsp_next_index),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_acc_now       (rsp_acc_now),
      .rsp_halted        (rsp_halted),
      .rsp_fault         (rsp_fault)
   );

   initial begin
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // Result side: check every accepted item, and pick a new stall mode now and then so
   // that free-running stretches alternate with coin-flip, patterned and heavy stalls.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         shadow.check_result({rsp_next_index, rsp_out_valid, rsp_out_value, rsp_acc_now,
                              rsp_halted, rsp_fault});
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(20, 150);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_phase <= rx_phase + 1;
      case (rx_mode)
         RX_FREE:    rsp_ready <= 1'b1;
         RX_COIN:    rsp_ready <= ($urandom_range(0, 1) == 1);
         RX_PATTERN: rsp_ready <= (rx_phase % 5) < 2;
         default:    rsp_ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   function automatic instr_type mk(logic [3:0] op, logic [1:0] sk, logic [31:0] sv, logic dk,
                                    logic [11:0] da, logic [11:0] bt, logic kn,
                                    logic [31:0] iv);
      instr_type ins;
      ins = '{op, sk, sv, dk, da, bt, kn, iv};
      return ins;
   endfunction

   // Favour the corners of the 32-bit range so that wrap-around turns up often.
   function automatic logic [31:0] wide_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0;
         4:       return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   // Keep most addresses in a small window so reads land on recent writes.
   function automatic logic [31:0] mem_addr();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 14) return $urandom_range(0, 15);
      if (pick < 19) return $urandom_range(0, MEM_WORDS - 1);
      return MEM_WORDS - 1;
   endfunction

   // Build an instruction that leaves the machine running: memory addresses in range,
   // taken branches to a known label inside the program, and a branch back whenever
   // the next index would run off the end.
   function automatic instr_type next_running_instr();
      instr_type   ins;
      int unsigned pick;
      int unsigned top_target;
      top_target = 32'(shadow.prog_len);
      top_target = top_target - 2;
      if (top_target > 4095) top_target = 4095;
      ins.input_value   = wide_value();
      ins.src_value     = wide_value();
      ins.dest_kind     = 1'($urandom_range(0, 1));
      ins.dest_addr     = 12'($urandom_range(0, 4095));
      ins.branch_target = 12'($urandom_range(0, 4095));
      ins.target_known  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      ins.src_kind = (pick < 3) ? SK_IMM : (pick < 5) ? SK_ACC : (pick < 9) ? SK_MEM : SK_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 10)      ins.op = OP_INP;
      else if (pick < 30) ins.op = OP_MOV;
      else if (pick < 42) ins.op = OP_OUT;
      else if (pick < 56) ins.op = OP_ADD;
      else if (pick < 68) ins.op = OP_SUB;
      else if (pick < 74) ins.op = OP_BRA;
      else if (pick < 80) ins.op = OP_BEZ;
      else if (pick < 86) ins.op = OP_BGZ;
      else if (pick < 92) ins.op = OP_BLZ;
      else if (pick < 96) ins.op = OP_LABEL;
      else                ins.op = 4'($urandom_range(OP_LABEL + 1, OP_TOP_UNUSED));
      if (shadow.index + 1 >= shadow.prog_len) ins.op = OP_BRA;
      if (ins.op >= OP_MOV && ins.op <= OP_SUB && ins.src_kind == SK_MEM)
         ins.src_value = mem_addr();
      if (ins.op == OP_MOV && ins.dest_kind) ins.dest_addr = 12'(mem_addr());
      if (shadow.branch_taken(ins.op)) begin
         ins.target_known  = 1'b1;
         ins.branch_target = 12'($urandom_range(0, top_target));
      end
      return ins;
   endfunction

   function automatic instr_type noise_instr();
      return mk(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), $urandom(),
                1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)), $urandom());
   endfunction

   // Offer one item and hold it until taken; open a new burst after a random gap.
   task automatic send_instr(input instr_type ins);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      {req_op, req_src_kind, req_src_value, req_dest_kind, req_dest_addr, req_branch_target,
       req_target_known, req_input_value} <= ins;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.note_instruction(ins);
   endtask

   // Drop valid, wait for every outstanding result, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_program_length(input logic [12:0] len);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow.set_program_length(len);
   endtask

   task automatic run_directed();
      // Accumulator extremes and wrap, with taken branches on sign
      send_instr(mk(OP_INP, SK_IMM, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
      send_instr(mk(OP_ADD, SK_IMM, 1, 0, 0, 0, 0, 0));
      send_instr(mk(OP_BLZ, SK_IMM, 0, 0, 0, 5, 1, 0));
      send_instr(mk(OP_SUB, SK_IMM, 1, 0, 0, 0, 0, 0));
      send_instr(mk(OP_BGZ, SK_IMM, 0, 0, 0, 0, 1, 0));
      // Moves through the top memory word
      send_instr(mk(OP_MOV, SK_ACC, 0, 1, 12'(MEM_WORDS - 1), 0, 0, 0));
      send_instr(mk(OP_MOV, SK_IMM, 32'h8000_0000, 0, 0, 0, 0, 0));
      send_instr(mk(OP_MOV, SK_MEM, MEM_WORDS - 1, 0, 0, 0, 0, 0));
      // Output from the accumulator, from memory and from source kind three, behaving as immediate
      send_instr(mk(OP_OUT, SK_ACC, 0, 0, 0, 0, 0, 0));
      send_instr(mk(OP_OUT, SK_MEM, 0, 0, 0, 0, 0, 0));
      send_instr(mk(OP_OUT, SK_SPARE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
      // Zero accumulator: branch to the highest target that keeps running, then back
      send_instr(mk(OP_SUB, SK_ACC, 0, 0, 0, 0, 0, 0));
      send_instr(mk(OP_BEZ, SK_IMM, 0, 0, 0, 12'(PROG_MAX - 2), 1, 0));
      send_instr(mk(OP_BRA, SK_IMM, 0, 0, 0, 2, 1, 0));
      // Untaken branches with unknown labels and ignored sources must not fault
      send_instr(mk(OP_BGZ, SK_MEM, 32'hFFFF_FFFF, 1, 12'hFFF, 12'hFFF, 0, 32'hFFFF_FFFF));
      send_instr(mk(OP_BLZ, SK_MEM, MEM_WORDS, 1, 12'hFFF, 12'hFFF, 0, 0));
      send_instr(mk(OP_LABEL, SK_MEM, 32'h8000_0000, 1, 12'hFFF, 12'hFFF, 1, 32'h8000_0000));
      send_instr(mk(OP_TOP_UNUSED, SK_MEM, MEM_WORDS, 1, 12'hFFF, 12'hFFF, 0, 32'hFFFF_FFFF));
      send_instr(mk(OP_INP, SK_MEM, 32'hFFFF_FFFF, 1, 12'hFFF, 0, 0, 32'h8000_0000));
      send_instr(mk(OP_BEZ, SK_IMM, 0, 0, 0, 12'hFFF, 0, 0));
      // Write then read the same word back to back, and memory to memory
      send_instr(mk(OP_MOV, SK_IMM, 32'h1234_5678, 1, 0, 0, 0, 0));
      send_instr(mk(OP_ADD, SK_MEM, 0, 0, 0, 0, 0, 0));
      send_instr(mk(OP_MOV, SK_MEM, 0, 1, 1, 0, 0, 0));
      send_instr(mk(OP_OUT, SK_MEM, 1, 0, 0, 0, 0, 0));
   endtask

   // Stop the machine once, by the given cause; nothing but reset can restart it.
   task automatic stop_machine(input stop_cause_type cause);
      instr_type ins;
      ins = next_running_instr();
      case (cause)
         END_HALT: ins.op = OP_HLT;
         END_LABEL: begin
            ins.op           = OP_BRA;
            ins.target_known = 1'b0;
         end
         END_SRC_ADDR: begin
            ins.op       = 4'($urandom_range(OP_MOV, OP_SUB));
            ins.src_kind = SK_MEM;
            case ($urandom_range(0, 2))
               0:       ins.src_value = MEM_WORDS;
               1:       ins.src_value = 32'hFFFF_FFFF;
               default: ins.src_value = $urandom_range(MEM_WORDS, 32'hFFFF_FFFF);
            endcase
         end
         END_DEST_ADDR: begin
            ins.op        = OP_MOV;
            ins.src_kind  = 2'($urandom_range(SK_IMM, SK_ACC));
            ins.dest_kind = 1'b1;
            ins.dest_addr = 12'($urandom_range(MEM_WORDS, 4095));
         end
         default: begin
            // Shrink the program under the current index so the next item ends it
            drain();
            write_program_length(13'($urandom_range(0, shadow.index)));
         end
      endcase
      send_instr(ins);
   endtask

   initial begin
      stop_cause_type cause;
      shadow = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // Length resets to zero, which would end the program at once
      write_program_length(PROG_MAX);
      run_directed();
      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            // Branch back near the start so that any new length still fits
            send_instr(mk(OP_BRA, SK_IMM, 0, 0, 0, 0, 1, 0));
            drain();
            case (ph)
               1:       write_program_length(13'($urandom_range(2049, 4095)));
               2:       write_program_length(13'($urandom_range(2, 6)));
               3:       write_program_length(13'($urandom_range(100, 2048)));
               default: write_program_length(PROG_MAX);
            endcase
         end
         repeat (PHASE_ITEMS) send_instr(next_running_instr());
      end
      cause = stop_cause_type'($urandom_range(END_HALT, END_PROGRAM));
      stop_machine(cause);
      // Once stopped, everything is ignored, even items that would otherwise fault
      repeat (8) send_instr(noise_instr());
      drain();
      write_program_length('0);
      repeat (6) send_instr(noise_instr());
      drain();
      $display("%0d items: directed corners, five random phases, one stop and ignored noise",
               shadow.executed);
      $display("%0d taken branches, %0d outputs; stopped by %s; %0d mismatches, %0d outstanding",
               shadow.taken_branches, shadow.outputs_seen, cause.name(), shadow.mismatches,
               shadow.pending());
      if (shadow.mismatches == 0 && shadow.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timed out with %0d results outstanding", shadow.pending());
      $display("status: fail");
      $finish;
   end

endmodule
